// ===== design/itt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the INI text tokenizer.
// Depends on nothing; used by the front end, the back end and the top level.
package itt_pkg;

  // Largest text size in bytes; offsets saturate at this size or at 65535.
  localparam int unsigned TEXT_BYTES_DEF  = 65536;
  // Depth of the token-group queue between the lexer and the output stage.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    KIND_COMMENT = 3'd0,
    KIND_INT     = 3'd1,
    KIND_REAL    = 3'd2,
    KIND_IDENT   = 3'd3,
    KIND_BOOL    = 3'd4,
    KIND_STRING  = 3'd5,
    KIND_SIGN    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] offset;
    logic [15:0] length;
    radix_e      radix;
    logic        bool_val;
  } token_t;

  // All tokens caused by one input beat: one, or two when a byte ends a
  // token and then starts a sign.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } group_t;

endpackage

// ===== design/ini_text_tokenizer.sv =====
`timescale 1ns / 1ps
// INI text tokenizer: takes one text byte per cycle unless stalled and
// returns comment, number, identifier, boolean, string and sign tokens
// as kind, offset and length. The lexer updates its state once per byte,
// so input beats are taken back to back; each byte yields zero, one or
// two tokens. Tokens wait in a QUEUE_DEPTH-entry queue of groups and leave
// one per cycle, unless the output stalls, through an output register, so a
// byte that gives two tokens takes two output beats; input stalls only when
// that queue is full. Depends on itt_pkg, itt_front, itt_fifo and itt_back.
module ini_text_tokenizer import itt_pkg::*; #(
  parameter int unsigned TEXT_BYTES  = TEXT_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [15:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic [1:0]  number_radix_o,
  output logic        bool_value_o,
  output logic        last_of_run_o
);

  localparam int unsigned GROUP_W = $bits(group_t);

  logic   in_fire;
  logic   push, pop, head_valid, full;
  group_t push_group, head_group;
  token_t out_tok;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  itt_front #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .char_byte_i  (char_byte_i),
    .end_of_text_i(end_of_text_i),
    .push_o       (push),
    .group_o      (push_group)
  );

  itt_fifo #(
    .WIDTH(GROUP_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_group),
    .pop_i  (pop),
    .data_o (head_group),
    .valid_o(head_valid),
    .full_o (full)
  );

  itt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_group),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_tok_o   (out_tok),
    .out_last_o  (last_of_run_o)
  );

  assign token_kind_o   = out_tok.kind;
  assign token_offset_o = out_tok.offset;
  assign token_length_o = out_tok.length;
  assign number_radix_o = out_tok.radix;
  assign bool_value_o   = out_tok.bool_val;

  // A full queue always has a token waiting in the output register.
  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("queue full while the output register is empty");

  a_sign_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == KIND_SIGN) |->
      (token_length_o == 16'd1) && last_of_run_o)
    else $error("sign beat with wrong length or not last of its byte");

  a_radix_only_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != KIND_INT) |-> (number_radix_o == RADIX_BIN))
    else $error("radix set on a non-integer beat");

  // The first of two tokens from one byte is followed by its partner.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && (token_kind_o == KIND_SIGN))
    else $error("first token of a pair not followed by its sign");

endmodule

// ===== design/itt_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue that decouples the lexer from the output stage.
// Generic in width and depth; no package dependencies.
module itt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == FULL_CNT);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/itt_front.sv =====
`timescale 1ns / 1ps
// Lexer front end: takes one text byte per beat, tracks the lexer mode and
// builds the group of tokens that the byte finishes. Depends on itt_pkg.
module itt_front import itt_pkg::*; #(
  parameter int unsigned TEXT_BYTES = TEXT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_text_i,
  output logic       push_o,
  output group_t     group_o
);

  localparam int unsigned POS_MAX_I = (TEXT_BYTES < 65535) ? TEXT_BYTES : 65535;
  localparam logic [15:0] POS_MAX   = POS_MAX_I[15:0];

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_D   = 8'h64;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_O   = 8'h6F;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_ZERO, MODE_INT,
    MODE_REAL, MODE_IDENT, MODE_QUOTES, MODE_STRING
  } mode_e;

  // Progress through the keywords TRUE and FALSE, case-insensitive.
  typedef enum logic [3:0] {
    TRK_NONE, TRK_T, TRK_TR, TRK_TRU, TRK_TRUE,
    TRK_F, TRK_FA, TRK_FAL, TRK_FALS, TRK_FALSE
  } trk_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_USCORE);
  endfunction

  function automatic trk_e track_next(input trk_e t, input logic [7:0] lc);
    trk_e n;
    n = TRK_NONE;
    unique case (t)
      TRK_T:    if (lc == CH_LO_R) n = TRK_TR;
      TRK_TR:   if (lc == CH_LO_U) n = TRK_TRU;
      TRK_TRU:  if (lc == CH_LO_E) n = TRK_TRUE;
      TRK_F:    if (lc == CH_LO_A) n = TRK_FA;
      TRK_FA:   if (lc == CH_LO_L) n = TRK_FAL;
      TRK_FAL:  if (lc == CH_LO_S) n = TRK_FALS;
      TRK_FALS: if (lc == CH_LO_E) n = TRK_FALSE;
      default:  n = TRK_NONE;
    endcase
    return n;
  endfunction

  mode_e       mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] start_q, start_d;
  radix_e      radix_q, radix_d;
  logic        qkind_q, qkind_d;
  logic [1:0]  qrun_q, qrun_d;
  logic        esc_q, esc_d;
  trk_e        trk_q, trk_d;

  logic [7:0]  c, lc, quote_ch;
  logic [15:0] pos_inc, span;
  logic        close_en, restart, sign_en;
  logic        close_has;
  token_t      close_tok, sign_tok;

  assign c        = char_byte_i;
  assign lc       = char_byte_i | 8'h20;
  assign quote_ch = qkind_q ? CH_SQUOTE : CH_DQUOTE;
  assign pos_inc  = (pos_q >= POS_MAX) ? POS_MAX : pos_q + 16'd1;
  assign span     = (pos_q >= start_q) ? pos_q - start_q : 16'd0;

  // Token pending in the current mode, ending before the current byte.
  always_comb begin
    close_has          = 1'b1;
    close_tok.kind     = KIND_COMMENT;
    close_tok.offset   = start_q;
    close_tok.length   = span;
    close_tok.radix    = RADIX_BIN;
    close_tok.bool_val = 1'b0;
    unique case (mode_q)
      MODE_COMMENT: close_tok.kind = KIND_COMMENT;
      MODE_ZERO: begin
        close_tok.kind  = KIND_INT;
        close_tok.radix = RADIX_DEC;
      end
      MODE_INT: begin
        close_tok.kind  = KIND_INT;
        close_tok.radix = radix_q;
      end
      MODE_REAL: close_tok.kind = KIND_REAL;
      MODE_IDENT: begin
        if (trk_q == TRK_TRUE) begin
          close_tok.kind     = KIND_BOOL;
          close_tok.bool_val = 1'b1;
        end else if (trk_q == TRK_FALSE) begin
          close_tok.kind = KIND_BOOL;
        end else begin
          close_tok.kind = KIND_IDENT;
        end
      end
      MODE_QUOTES: begin
        close_tok.kind = KIND_STRING;
        // A doubled quote is an empty string; a longer run yields nothing.
        if (qrun_q == 2'd2) begin
          close_tok.length = 16'd0;
        end else if (qrun_q != 2'd1) begin
          close_has = 1'b0;
        end
      end
      MODE_STRING: close_tok.kind = KIND_STRING;
      default: close_has = 1'b0;
    endcase
  end

  always_comb begin
    sign_tok.kind     = KIND_SIGN;
    sign_tok.offset   = pos_q;
    sign_tok.length   = 16'd1;
    sign_tok.radix    = RADIX_BIN;
    sign_tok.bool_val = 1'b0;
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    start_d  = start_q;
    radix_d  = radix_q;
    qkind_d  = qkind_q;
    qrun_d   = qrun_q;
    esc_d    = esc_q;
    trk_d    = trk_q;
    close_en = 1'b0;
    restart  = 1'b0;
    sign_en  = 1'b0;

    if (end_of_text_i) begin
      close_en = 1'b1;
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      start_d  = '0;
      radix_d  = RADIX_DEC;
      qkind_d  = 1'b0;
      qrun_d   = '0;
      esc_d    = 1'b0;
      trk_d    = TRK_NONE;
    end else begin
      pos_d = pos_inc;
      unique case (mode_q)
        MODE_IDLE: restart = 1'b1;
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            close_en = 1'b1;
            restart  = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (is_digit(c) || (c == CH_LO_D)) begin
            mode_d  = MODE_INT;
            radix_d = RADIX_DEC;
          end else if (c == CH_LO_B) begin
            mode_d  = MODE_INT;
            radix_d = RADIX_BIN;
          end else if (c == CH_LO_O) begin
            mode_d  = MODE_INT;
            radix_d = RADIX_OCT;
          end else if (c == CH_LO_X) begin
            mode_d  = MODE_INT;
            radix_d = RADIX_HEX;
          end else if (c == CH_DOT) begin
            mode_d = MODE_REAL;
          end else begin
            close_en = 1'b1;
            restart  = 1'b1;
          end
        end
        MODE_INT: begin
          if ((radix_q == RADIX_HEX) ? is_hex(c) : is_digit(c)) begin
            mode_d = MODE_INT;
          end else if ((c == CH_DOT) && (radix_q == RADIX_DEC)) begin
            mode_d = MODE_REAL;
          end else if ((c == CH_DOT) && (radix_q != RADIX_HEX)) begin
            // A binary or octal number followed by a dot is dropped with it.
            mode_d = MODE_IDLE;
          end else begin
            close_en = 1'b1;
            restart  = 1'b1;
          end
        end
        MODE_REAL: begin
          if (!is_digit(c)) begin
            close_en = 1'b1;
            restart  = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_word(c)) begin
            trk_d = track_next(trk_q, lc);
          end else begin
            close_en = 1'b1;
            restart  = 1'b1;
          end
        end
        MODE_QUOTES: begin
          if (c == quote_ch) begin
            qrun_d = (qrun_q == 2'd3) ? 2'd3 : qrun_q + 2'd1;
          end else if (qrun_q == 2'd1) begin
            mode_d = MODE_STRING;
            esc_d  = (c == CH_BSLASH);
          end else begin
            close_en = 1'b1;
            restart  = 1'b1;
          end
        end
        MODE_STRING: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (c == quote_ch) begin
            close_en = 1'b1;
          end else if (c == CH_BSLASH) begin
            esc_d = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase

      if (close_en) begin
        mode_d = MODE_IDLE;
      end

      // The byte that ended a token (other than a closing string quote), or any
      // byte seen between tokens, is lexed again as a possible token start.
      if (restart) begin
        if (c == CH_HASH) begin
          mode_d  = MODE_COMMENT;
          start_d = pos_q;
        end else if (is_digit(c)) begin
          mode_d  = (c == CH_ZERO) ? MODE_ZERO : MODE_INT;
          radix_d = RADIX_DEC;
          start_d = pos_q;
        end else if (is_word(c)) begin
          mode_d  = MODE_IDENT;
          start_d = pos_q;
          trk_d   = (lc == CH_LO_T) ? TRK_T : ((lc == CH_LO_F) ? TRK_F : TRK_NONE);
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
          mode_d  = MODE_QUOTES;
          qkind_d = (c == CH_SQUOTE);
          qrun_d  = 2'd1;
          esc_d   = 1'b0;
          start_d = pos_inc;
        end else if (c == CH_PLUS) begin
          sign_en = 1'b1;
        end
      end
    end
  end

  logic close_valid;
  assign close_valid    = close_en && close_has;
  assign push_o         = in_fire_i && (close_valid || sign_en);
  assign group_o.first  = close_valid ? close_tok : sign_tok;
  assign group_o.second = sign_tok;
  assign group_o.two    = close_valid && sign_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      radix_q <= RADIX_DEC;
      qkind_q <= 1'b0;
      qrun_q  <= '0;
      esc_q   <= 1'b0;
      trk_q   <= TRK_NONE;
    end else if (in_fire_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      radix_q <= radix_d;
      qkind_q <= qkind_d;
      qrun_q  <= qrun_d;
      esc_q   <= esc_d;
      trk_q   <= trk_d;
    end
  end

endmodule

// ===== design/itt_back.sv =====
`timescale 1ns / 1ps
// Output stage: takes token groups from the queue and hands them out one
// token per beat through an output register. Depends on itt_pkg.
module itt_back import itt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   head_valid_i,
  input  group_t head_i,
  output logic   pop_o,
  input  logic   out_stall_i,
  output logic   out_valid_o,
  output token_t out_tok_o,
  output logic   out_last_o
);

  logic   valid_q, valid_d;
  logic   half_q, half_d;
  token_t tok_q, tok_d;
  logic   last_q, last_d;
  logic   load;

  // The register may refill whenever it is empty or its beat leaves now.
  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    tok_d   = tok_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.two && !half_q) begin
          tok_d  = head_i.first;
          last_d = 1'b0;
          half_d = 1'b1;
        end else begin
          tok_d  = half_q ? head_i.second : head_i.first;
          last_d = 1'b1;
          half_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

endmodule

// ===== dv/ini_text_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ini_text_tokenizer: feeds INI-like text and noise with random
// gaps and stalls, predicts every token in SystemVerilog and compares each output beat.
// Depends on itt_pkg and the ini_text_tokenizer RTL.
module ini_text_tokenizer_tb;
  import itt_pkg::*;

  localparam int unsigned POS_CAP       = (TEXT_BYTES_DEF < 65535) ? TEXT_BYTES_DEF : 65535;
  localparam int unsigned RANDOM_BYTES  = 2000;
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [7:0]  CH_NL         = 8'h0A;
  localparam logic [7:0]  CH_DQUOTE     = 8'h22;
  localparam logic [7:0]  CH_SQUOTE     = 8'h27;
  localparam logic [7:0]  CH_BSLASH     = 8'h5C;

  typedef enum logic [3:0] {
    LX_IDLE, LX_COMMENT, LX_ZERO, LX_INT, LX_REAL, LX_WORD, LX_QUOTES, LX_STRING
  } lex_mode_e;

  // Progress through the letters of TRUE or FALSE, case folded.
  typedef enum logic [4:0] {
    KW_NONE, KW_T, KW_TR, KW_TRU, KW_TRUE, KW_F, KW_FA, KW_FAL, KW_FALS, KW_FALSE
  } kw_e;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic [2:0] gap;
    logic       drain;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  token_kind;
  logic [15:0] token_offset;
  logic [15:0] token_length;
  logic [1:0]  number_radix;
  logic        bool_value;
  logic        last_of_run;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  ini_text_tokenizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_byte_i    (char_byte),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .token_offset_o (token_offset),
    .token_length_o (token_length),
    .number_radix_o (number_radix),
    .bool_value_o   (bool_value),
    .last_of_run_o  (last_of_run)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  logic [15:0] pos_q;
  logic [15:0] start_q;
  lex_mode_e   mode_q;
  radix_e      radix_q;
  logic        single_quote_q;
  logic [1:0]  quote_cnt_q;
  logic        escaped_q;
  kw_e         kw_q;

  token_t      step_toks[$];
  token_beat_t tokens_due[$];
  int unsigned kind_cnt[7];
  int unsigned errors = 0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == "-" || c == "_";
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] p);
    return (p >= POS_CAP) ? 16'(POS_CAP) : p + 16'd1;
  endfunction

  function automatic logic [15:0] span(logic [15:0] p);
    return (p >= start_q) ? p - start_q : 16'd0;
  endfunction

  function automatic kw_e kw_advance(kw_e t, logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    case (t)
      KW_T:    return (lc == "r") ? KW_TR : KW_NONE;
      KW_TR:   return (lc == "u") ? KW_TRU : KW_NONE;
      KW_TRU:  return (lc == "e") ? KW_TRUE : KW_NONE;
      KW_F:    return (lc == "a") ? KW_FA : KW_NONE;
      KW_FA:   return (lc == "l") ? KW_FAL : KW_NONE;
      KW_FAL:  return (lc == "s") ? KW_FALS : KW_NONE;
      KW_FALS: return (lc == "e") ? KW_FALSE : KW_NONE;
      default: return KW_NONE;
    endcase
  endfunction

  function automatic void note_token(kind_e kind, logic [15:0] off, logic [15:0] len,
                                     radix_e rdx, logic bval);
    token_t t;
    t.kind     = kind;
    t.offset   = off;
    t.length   = len;
    t.radix    = rdx;
    t.bool_val = bval;
    step_toks.push_back(t);
  endfunction

  function automatic void reset_lexer();
    pos_q          = '0;
    start_q        = '0;
    mode_q         = LX_IDLE;
    radix_q        = RADIX_DEC;
    single_quote_q = 1'b0;
    quote_cnt_q    = '0;
    escaped_q      = 1'b0;
    kw_q           = KW_NONE;
  endfunction

  // Emits whatever token is open, ending just before position p.
  function automatic void close_pending(logic [15:0] p);
    case (mode_q)
      LX_COMMENT: note_token(KIND_COMMENT, start_q, span(p), RADIX_BIN, 1'b0);
      LX_ZERO:    note_token(KIND_INT, start_q, span(p), RADIX_DEC, 1'b0);
      LX_INT:     note_token(KIND_INT, start_q, span(p), radix_q, 1'b0);
      LX_REAL:    note_token(KIND_REAL, start_q, span(p), RADIX_BIN, 1'b0);
      LX_WORD: begin
        if (kw_q == KW_TRUE) note_token(KIND_BOOL, start_q, span(p), RADIX_BIN, 1'b1);
        else if (kw_q == KW_FALSE) note_token(KIND_BOOL, start_q, span(p), RADIX_BIN, 1'b0);
        else note_token(KIND_IDENT, start_q, span(p), RADIX_BIN, 1'b0);
      end
      LX_QUOTES: begin
        // A run of three or more quotes yields nothing at all.
        if (quote_cnt_q == 2'd1) note_token(KIND_STRING, start_q, span(p), RADIX_BIN, 1'b0);
        else if (quote_cnt_q == 2'd2) note_token(KIND_STRING, start_q, 16'd0, RADIX_BIN, 1'b0);
      end
      LX_STRING:  note_token(KIND_STRING, start_q, span(p), RADIX_BIN, 1'b0);
      default: ;
    endcase
    mode_q = LX_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] c, logic [15:0] p);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c == "#") begin
      mode_q  = LX_COMMENT;
      start_q = p;
    end else if (is_digit(c)) begin
      mode_q  = (c == "0") ? LX_ZERO : LX_INT;
      radix_q = RADIX_DEC;
      start_q = p;
    end else if (is_word(c)) begin
      mode_q  = LX_WORD;
      start_q = p;
      kw_q    = (lc == "t") ? KW_T : ((lc == "f") ? KW_F : KW_NONE);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      mode_q         = LX_QUOTES;
      single_quote_q = (c == CH_SQUOTE);
      quote_cnt_q    = 2'd1;
      escaped_q      = 1'b0;
      start_q        = sat_inc(p);
    end else if (c == "+") begin
      note_token(KIND_SIGN, p, 16'd1, RADIX_BIN, 1'b0);
    end
  endfunction

  // Returns 1 when the byte ended the open token, or none was open, and must start a new one.
  function automatic bit continue_token(logic [7:0] c, logic [15:0] p);
    logic [7:0] quote;
    quote = single_quote_q ? CH_SQUOTE : CH_DQUOTE;
    case (mode_q)
      LX_IDLE: return 1'b1;
      LX_COMMENT: begin
        if (c != CH_NL) return 1'b0;
      end
      LX_ZERO: begin
        if (is_digit(c) || c == "d") begin
          mode_q  = LX_INT;
          radix_q = RADIX_DEC;
          return 1'b0;
        end
        if (c == "b") begin
          mode_q  = LX_INT;
          radix_q = RADIX_BIN;
          return 1'b0;
        end
        if (c == "o") begin
          mode_q  = LX_INT;
          radix_q = RADIX_OCT;
          return 1'b0;
        end
        if (c == "x") begin
          mode_q  = LX_INT;
          radix_q = RADIX_HEX;
          return 1'b0;
        end
        if (c == ".") begin
          mode_q = LX_REAL;
          return 1'b0;
        end
      end
      LX_INT: begin
        if ((radix_q == RADIX_HEX) ? is_hex(c) : is_digit(c)) return 1'b0;
        if (c == "." && radix_q == RADIX_DEC) begin
          mode_q = LX_REAL;
          return 1'b0;
        end
        // Binary and octal numbers are dropped along with the dot.
        if (c == "." && radix_q != RADIX_HEX) begin
          mode_q = LX_IDLE;
          return 1'b0;
        end
      end
      LX_REAL: begin
        if (is_digit(c)) return 1'b0;
      end
      LX_WORD: begin
        if (is_word(c)) begin
          kw_q = kw_advance(kw_q, c);
          return 1'b0;
        end
      end
      LX_QUOTES: begin
        if (c == quote) begin
          if (quote_cnt_q < 2'd3) quote_cnt_q++;
          return 1'b0;
        end
        if (quote_cnt_q == 2'd1) begin
          mode_q    = LX_STRING;
          escaped_q = (c == CH_BSLASH);
          return 1'b0;
        end
      end
      LX_STRING: begin
        if (escaped_q) escaped_q = 1'b0;
        else if (c == quote) close_pending(p);
        else if (c == CH_BSLASH) escaped_q = 1'b1;
        return 1'b0;
      end
      default: ;
    endcase
    close_pending(p);
    return 1'b1;
  endfunction

  function automatic void lex_step(logic eot, logic [7:0] c);
    token_beat_t b;
    step_toks.delete();
    if (eot) begin
      close_pending(pos_q);
      reset_lexer();
    end else begin
      if (continue_token(c, pos_q)) open_token(c, pos_q);
      pos_q = sat_inc(pos_q);
    end
    foreach (step_toks[i]) begin
      b.tok  = step_toks[i];
      b.last = (i == step_toks.size() - 1);
      tokens_due.push_back(b);
      kind_cnt[step_toks[i].kind]++;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents one byte beat after the gap drawn for it
  // ---------------------------------------------------------------------------
  text_beat_t  pend_q[$];
  text_beat_t  nxt;
  bit          staged = 1'b0;
  int unsigned gap_left = 0;
  int unsigned bytes_taken = 0;
  int unsigned eots_taken = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      char_byte   <= 8'h00;
      end_of_text <= 1'b0;
    end else begin
      if (in_fire) begin
        lex_step(end_of_text, char_byte);
        if (end_of_text) eots_taken++;
        else bytes_taken++;
      end
      if (!in_valid || in_fire) begin
        if (!staged && pend_q.size() != 0) begin
          nxt      = pend_q.pop_front();
          staged   = 1'b1;
          gap_left = nxt.gap;
        end
        // A drain beat holds off until every predicted token has come out.
        if (staged && gap_left == 0 && !(nxt.drain && tokens_due.size() != 0)) begin
          in_valid    <= 1'b1;
          char_byte   <= nxt.ch;
          end_of_text <= nxt.eot;
          staged = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (staged && gap_left > 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall after each token beat, with calm stretches
  // ---------------------------------------------------------------------------
  int unsigned hold = 0;
  int unsigned rx_calm_left = 0;
  token_beat_t want;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d offset %0d length %0d",
                   $time, token_kind, token_offset, token_length);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 16'(want.tok.kind), 16'(token_kind));
          check_field("token_offset", want.tok.offset, token_offset);
          check_field("token_length", want.tok.length, token_length);
          check_field("number_radix", 16'(want.tok.radix), 16'(number_radix));
          check_field("bool_value", 16'(want.tok.bool_val), 16'(bool_value));
          check_field("last_of_run", 16'(want.last), 16'(last_of_run));
        end
        if (rx_calm_left > 0) begin
          rx_calm_left--;
          hold = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          rx_calm_left = $urandom_range(20, 100);
          hold = 0;
        end else begin
          hold = $urandom_range(0, 7);
        end
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bit          tx_calm = 1'b0;
  bit          drain_next = 1'b0;
  int unsigned queued_bytes = 0;

  task automatic add_beat(logic [7:0] c, logic eot);
    text_beat_t b;
    b.ch    = c;
    b.eot   = eot;
    b.gap   = tx_calm ? 3'd0 : 3'($urandom_range(0, 7));
    b.drain = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(b);
    if (!eot) queued_bytes++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0);
  endtask

  initial begin
    int unsigned piece;
    int unsigned n;
    int unsigned base;
    logic [7:0]  c;
    logic [7:0]  q;
    string       s;
    string       hexset;
    string       wordset;

    hexset  = "0123456789abcdefABCDEF";
    wordset = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_0123456789";
    reset_lexer();

    // Directed: comment with a top-bit byte, hex then dot, octal then dot, number
    // followed by a sign, real from a lone zero, boolean ended by quotes, empty
    // string, a quote run, a null byte, an unclosed string and a lone quote.
    add_text("#");
    add_beat(8'hFF, 1'b0);
    add_beat(CH_NL, 1'b0);
    add_text("0x1F.0o7.9+0.5 fAlSe''\"\"\"");
    add_beat(8'h00, 1'b0);
    add_text("'x");
    add_beat(8'hFF, 1'b1);
    add_text("\"");
    add_beat(8'h00, 1'b1);

    // Random INI-like text with noise.
    drain_next = 1'b1;
    base = queued_bytes;
    while (queued_bytes - base < RANDOM_BYTES) begin
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      piece = $urandom_range(0, 99);
      if (piece < 10) begin
        add_text("#");
        n = $urandom_range(0, 10);
        repeat (n) add_beat(8'($urandom_range(32, 126)), 1'b0);
        if ($urandom_range(0, 4) != 0) add_beat(CH_NL, 1'b0);
      end else if (piece < 30) begin
        n = $urandom_range(0, 5);
        if (n < 4) begin
          add_text("0");
          add_text(n == 0 ? "b" : n == 1 ? "o" : n == 2 ? "d" : "x");
        end
        repeat ((n < 4) ? $urandom_range(0, 4) : $urandom_range(1, 5)) begin
          if (n == 3) add_beat(hexset[$urandom_range(0, hexset.len() - 1)], 1'b0);
          else add_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        if ($urandom_range(0, 9) < 3) begin
          add_text(".");
          repeat ($urandom_range(0, 3)) add_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
      end else if (piece < 50) begin
        if ($urandom_range(0, 9) < 4) begin
          s = $urandom_range(0, 1) ? "true" : "false";
          n = $urandom_range(0, 9);
          if (n == 0) s = s.substr(0, s.len() - 2);
          else if (n == 1) s = {s, "e"};
          for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if ($urandom_range(0, 1)) c = c & 8'hDF;
            add_beat(c, 1'b0);
          end
        end else begin
          add_beat(wordset[$urandom_range(0, 53)], 1'b0);
          repeat ($urandom_range(0, 6)) add_beat(wordset[$urandom_range(0, 63)], 1'b0);
        end
      end else if (piece < 62) begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        add_beat(q, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_beat(CH_BSLASH, 1'b0);
            add_beat(8'($urandom_range(0, 255)), 1'b0);
          end else begin
            add_beat(8'($urandom_range(32, 126)), 1'b0);
          end
        end
        if ($urandom_range(0, 9) != 0) add_beat(q, 1'b0);
      end else if (piece < 67) begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        repeat ($urandom_range(2, 4)) add_beat(q, 1'b0);
      end else if (piece < 72) begin
        add_text("+");
      end else if (piece < 90) begin
        s = " =[],;\t";
        if ($urandom_range(0, 3) == 0) add_beat(CH_NL, 1'b0);
        else add_beat(s[$urandom_range(0, s.len() - 1)], 1'b0);
      end else if (piece < 97) begin
        add_beat(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_beat(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    // Closing texts: a mix of tokens sent back to back after a full drain, then one with random gaps.
    add_beat(8'h00, 1'b1);
    drain_next = 1'b1;
    tx_calm = 1'b1;
    add_text("ab 1+ 'x' 0x7");
    add_beat(8'h00, 1'b1);
    tx_calm = 1'b0;
    add_text("k=1");
    add_beat(8'h00, 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pend_q.size() != 0 || staged || in_valid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Lexed %0d bytes over %0d texts of directed and random INI-like input.",
             bytes_taken, eots_taken);
    $display("Tokens checked: %0d comment, %0d int, %0d real, %0d ident,",
             kind_cnt[KIND_COMMENT], kind_cnt[KIND_INT], kind_cnt[KIND_REAL],
             kind_cnt[KIND_IDENT]);
    $display("  %0d bool, %0d string, %0d sign.",
             kind_cnt[KIND_BOOL], kind_cnt[KIND_STRING], kind_cnt[KIND_SIGN]);
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
